/* hdl/ismu_pkg.sv */
// ----------------------------------------------------------------------------
// ismu_pkg
// Shared constants, types and command/status bundles for the Ising
// Metropolis site update block.
// ----------------------------------------------------------------------------
package ismu_pkg;

	// Lattice geometry: the side is a power of two so row and column are fields
	localparam int SIDE_LOG2 = 6;
	localparam int SIDE      = 1 << SIDE_LOG2;
	localparam int VOL       = SIDE * SIDE;
	localparam int ADDR_W    = 2 * SIDE_LOG2;

	// Field widths
	localparam int SITE_W   = 12;
	localparam int RAND_W   = 32;
	localparam int THRESH_W = 32;
	localparam int ENERGY_W = 15;
	localparam int SUM_W    = 14;
	localparam int MAG_W    = 13;
	localparam int H_W      = 4;  // neighbour sum, -4..4
	localparam int DE_W     = 5;  // energy change, -8..8

	// Reset values of the running totals (all spins up)
	localparam logic signed [ENERGY_W-1:0] ENERGY_RESET = ENERGY_W'(-2 * VOL);
	localparam logic signed [SUM_W-1:0]    SUM_RESET    = SUM_W'(VOL);

	// Item kinds
	localparam logic KIND_UPDATE = 1'b0;
	localparam logic KIND_SET    = 1'b1;

	// Configuration register indexes
	localparam logic CFG_THRESH_4 = 1'b0;
	localparam logic CFG_THRESH_8 = 1'b1;

	// Spin encoding in the store
	localparam logic SPIN_UP = 1'b1;

	// Read order of the five spins of one site
	typedef enum logic [2:0] {
		NB_CENTRE = 3'd0,
		NB_DOWN   = 3'd1,
		NB_UP     = 3'd2,
		NB_RIGHT  = 3'd3,
		NB_LEFT   = 3'd4
	} nb_sel_t;

	typedef struct packed {
		logic              load_item;
		logic              rd_en;
		nb_sel_t           rd_sel;
		logic              cap_en;
		nb_sel_t           cap_sel;
		logic              commit;
		logic              clr_en;
		logic [ADDR_W-1:0] clr_addr;
	} ismu_cmd_t;

	typedef struct packed {
		logic out_free;
	} ismu_status_t;

endpackage

/* hdl/ismu_ram.sv */
// ----------------------------------------------------------------------------
// ismu_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ismu_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* hdl/ismu_ctrl.sv */
// ----------------------------------------------------------------------------
// ismu_ctrl
// Sequencer: clearing pass, item intake, five spin reads, decision, commit.
// ----------------------------------------------------------------------------
module ismu_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  ismu_pkg::ismu_status_t status,
	output ismu_pkg::ismu_cmd_t    cmd
);
	import ismu_pkg::*;

	typedef enum logic [4:0] {
		ST_CLEAR  = 5'b00001,
		ST_IDLE   = 5'b00010,
		ST_FETCH  = 5'b00100,
		ST_DECIDE = 5'b01000,
		ST_COMMIT = 5'b10000
	} state_t;

	state_t            state_q, state_d;
	logic [ADDR_W-1:0] clr_cnt_q;
	nb_sel_t           rd_sel_q;
	logic              cap_en_q;
	nb_sel_t           cap_sel_q;
	logic              accept;

	assign accept   = in_valid && (state_q == ST_IDLE);
	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_cnt_q == ADDR_W'(VOL - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) state_d = ST_FETCH;
			end
			ST_FETCH: begin
				if (rd_sel_q == NB_LEFT) state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				state_d = ST_COMMIT;
			end
			ST_COMMIT: begin
				if (status.out_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_cnt_q <= '0;
			rd_sel_q  <= NB_CENTRE;
			cap_en_q  <= 1'b0;
			cap_sel_q <= NB_CENTRE;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
			end
			if (accept) begin
				rd_sel_q <= NB_CENTRE;
			end else if (state_q == ST_FETCH) begin
				rd_sel_q <= nb_sel_t'(rd_sel_q + 3'd1);
			end
			// read data is registered: capture in the cycle after the read
			cap_en_q  <= (state_q == ST_FETCH);
			cap_sel_q <= rd_sel_q;
		end
	end

	always_comb begin
		cmd.load_item = accept;
		cmd.rd_en     = (state_q == ST_FETCH);
		cmd.rd_sel    = rd_sel_q;
		cmd.cap_en    = cap_en_q;
		cmd.cap_sel   = cap_sel_q;
		cmd.commit    = (state_q == ST_COMMIT) && status.out_free;
		cmd.clr_en    = (state_q == ST_CLEAR);
		cmd.clr_addr  = clr_cnt_q;
	end

endmodule

/* hdl/ismu_dp.sv */
// ----------------------------------------------------------------------------
// ismu_dp
// Datapath: item registers, spin store, neighbour sum, Metropolis decision,
// running energy and spin sum, output register.
// ----------------------------------------------------------------------------
module ismu_dp (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  ismu_pkg::ismu_cmd_t                     cmd,
	output ismu_pkg::ismu_status_t                  status,
	input  logic                                   cfg_write,
	input  logic                                   cfg_index,
	input  logic [ismu_pkg::THRESH_W-1:0]          cfg_wdata,
	input  logic                                   kind,
	input  logic [ismu_pkg::SITE_W-1:0]            site_index,
	input  logic [ismu_pkg::RAND_W-1:0]            random_value,
	input  logic                                   spin_value,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic                                   accepted,
	output logic signed [ismu_pkg::ENERGY_W-1:0]   energy,
	output logic [ismu_pkg::MAG_W-1:0]             magnetisation_abs
);
	import ismu_pkg::*;

	// configuration
	logic [THRESH_W-1:0] thresh4_q, thresh8_q;

	// current item
	logic              kind_q;
	logic [SITE_W-1:0] site_q;
	logic [RAND_W-1:0] rnd_q;
	logic              spin_q;

	// gathered spins
	logic                  s_q;
	logic signed [H_W-1:0] h_q;

	// running totals
	logic signed [ENERGY_W-1:0] energy_q;
	logic signed [SUM_W-1:0]    sum_q;

	// output register
	logic                       out_valid_q;
	logic                       acc_q;
	logic signed [ENERGY_W-1:0] out_energy_q;
	logic [MAG_W-1:0]           out_mag_q;

	// addressing
	logic [ADDR_W-1:0]    addr;
	logic [SIDE_LOG2-1:0] row, col;
	logic [ADDR_W-1:0]    raddr;
	logic                 in_range;

	// store ports
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic              ram_wdata;
	logic              ram_rdata;

	// decision
	logic signed [H_W-1:0]      hs;
	logic signed [DE_W-1:0]     de;
	logic                       flip, do_flip, acc;
	logic signed [ENERGY_W-1:0] energy_nxt;
	logic signed [SUM_W-1:0]    sum_nxt, sum_neg;
	logic [MAG_W-1:0]           mag_nxt;

	assign addr     = ADDR_W'(site_q);
	assign row      = addr[ADDR_W-1:SIDE_LOG2];
	assign col      = addr[SIDE_LOG2-1:0];
	assign in_range = int'(site_q) < VOL;

	// torus neighbours: row and column wrap by field overflow
	always_comb begin
		case (cmd.rd_sel)
			NB_CENTRE: raddr = addr;
			NB_DOWN:   raddr = {row + SIDE_LOG2'(1), col};
			NB_UP:     raddr = {row - SIDE_LOG2'(1), col};
			NB_RIGHT:  raddr = {row, col + SIDE_LOG2'(1)};
			NB_LEFT:   raddr = {row, col - SIDE_LOG2'(1)};
			default:   raddr = addr;
		endcase
	end

	assign ram_we    = cmd.clr_en || (cmd.commit && do_flip);
	assign ram_waddr = cmd.clr_en ? cmd.clr_addr : addr;
	assign ram_wdata = cmd.clr_en ? SPIN_UP : !s_q;

	ismu_ram #(
		.WIDTH (1),
		.DEPTH (VOL)
	) u_spin_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.rd_en),
		.raddr (raddr),
		.rdata (ram_rdata)
	);

	// dE = 2*s*h
	assign hs = (s_q == SPIN_UP) ? h_q : -h_q;
	assign de = DE_W'(hs) <<< 1;

	always_comb begin
		if (kind_q == KIND_UPDATE) begin
			if (de[DE_W-1] || (de == '0)) begin
				flip = 1'b1;
			end else if (de == DE_W'(4)) begin
				flip = rnd_q < thresh4_q;
			end else begin
				flip = rnd_q < thresh8_q;
			end
		end else begin
			flip = (s_q != spin_q);
		end
	end

	assign do_flip    = in_range && flip;
	assign acc        = do_flip && (kind_q == KIND_UPDATE);
	assign energy_nxt = energy_q + (do_flip ? ENERGY_W'(de) : '0);

	always_comb begin
		if (!do_flip) begin
			sum_nxt = sum_q;
		end else if (s_q == SPIN_UP) begin
			sum_nxt = sum_q - SUM_W'(2);
		end else begin
			sum_nxt = sum_q + SUM_W'(2);
		end
	end

	assign sum_neg = -sum_nxt;
	assign mag_nxt = sum_nxt[SUM_W-1] ? MAG_W'(sum_neg) : MAG_W'(sum_nxt);

	assign status.out_free = !out_valid_q || !out_stall;

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			kind_q <= kind;
			site_q <= site_index;
			rnd_q  <= random_value;
			spin_q <= spin_value;
		end
		if (cmd.load_item) begin
			h_q <= '0;
		end else if (cmd.cap_en) begin
			if (cmd.cap_sel == NB_CENTRE) begin
				s_q <= ram_rdata;
			end else if (ram_rdata == SPIN_UP) begin
				h_q <= h_q + H_W'(1);
			end else begin
				h_q <= h_q - H_W'(1);
			end
		end
		if (cmd.commit) begin
			acc_q        <= acc;
			out_energy_q <= energy_nxt;
			out_mag_q    <= mag_nxt;
		end
	end

	// control and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh4_q   <= '0;
			thresh8_q   <= '0;
			energy_q    <= ENERGY_RESET;
			sum_q       <= SUM_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					CFG_THRESH_4: thresh4_q <= cfg_wdata;
					CFG_THRESH_8: thresh8_q <= cfg_wdata;
					default: ;
				endcase
			end
			if (cmd.commit) begin
				energy_q <= energy_nxt;
				sum_q    <= sum_nxt;
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid         = out_valid_q;
	assign accepted          = acc_q;
	assign energy            = out_energy_q;
	assign magnetisation_abs = out_mag_q;

endmodule

/* hdl/ising_metropolis_site_update.sv */
// ----------------------------------------------------------------------------
// ising_metropolis_site_update
// Metropolis single-site update engine for a square Ising lattice on a torus,
// with running energy and magnetisation.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake            payload
//  -------  ---------  -------------------  ---------------------------------
//  in       sink       in_valid / in_stall  kind, site_index, random_value,
//                                           spin_value
//  out      source     out_valid/out_stall  accepted, energy,
//                                           magnetisation_abs
//  cfg      sink       cfg_write            cfg_index, cfg_wdata
//
//  Sequence: each transaction passes intake, five reads of the single
//  read port of the spin RAM (site and four neighbours), decide, commit;
//  a new one is taken only after commit, so that read port sets the pace.
//  Reset: a clearing pass writes every spin to +1, one site per clock
//  (VOL = 4096 sites at a side of 64); in_stall stays high meanwhile.
//  Configuration writes are taken at any time, including the clearing pass.
//  Stalls: the result sits in an output register; the next transaction is
//  taken and worked on while it waits, and holds at commit until it leaves.
//
module ising_metropolis_site_update (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration
	input  logic                                 cfg_write,
	input  logic                                 cfg_index,
	input  logic [ismu_pkg::THRESH_W-1:0]        cfg_wdata,
	// item channel
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 kind,
	input  logic [ismu_pkg::SITE_W-1:0]          site_index,
	input  logic [ismu_pkg::RAND_W-1:0]          random_value,
	input  logic                                 spin_value,
	// result channel
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic                                 accepted,
	output logic signed [ismu_pkg::ENERGY_W-1:0] energy,
	output logic [ismu_pkg::MAG_W-1:0]           magnetisation_abs
);
	import ismu_pkg::*;

	ismu_cmd_t    cmd;
	ismu_status_t status;

	// sequencer
	ismu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	// spin store, arithmetic and output register
	ismu_dp u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.status            (status),
		.cfg_write         (cfg_write),
		.cfg_index         (cfg_index),
		.cfg_wdata         (cfg_wdata),
		.kind              (kind),
		.site_index        (site_index),
		.random_value      (random_value),
		.spin_value        (spin_value),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.accepted          (accepted),
		.energy            (energy),
		.magnetisation_abs (magnetisation_abs)
	);

endmodule

/* tb/sv/tb_ising_metropolis_site_update.sv */
// ----------------------------------------------------------------------------
// tb_ising_metropolis_site_update
// Self-checking bench for the Ising Metropolis site update block. A lattice
// predictor runs in step with every accepted transaction and queues the
// expected accept flag, energy and |M|. A checker compares each result
// transaction against the oldest queued entry. Directed cases cover sets,
// dE of -8/-4/0/4/8, torus wrap and threshold edges. Random traffic follows,
// biased towards neighbouring sites to stress read/write forwarding, under
// varied idling and an output hold-off.
// ----------------------------------------------------------------------------
module tb_ising_metropolis_site_update;
	timeunit 1ns;
	timeprecision 1ps;

	import ismu_pkg::*;

	// No transaction on either channel for this long means a hang. Covers the
	// clearing pass after reset and the output hold-off with a wide margin.
	localparam int QUIET_LIMIT  = 20000;
	localparam int DRAIN_GAP    = 16;
	localparam int HOLDOFF_LEN  = 300;
	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic                       accepted;
		logic signed [ENERGY_W-1:0] energy;
		logic [MAG_W-1:0]           magnetisation_abs;
	} site_result_t;

	// DUT ports, every input driven to a known value from time zero
	logic                       clk          = 1'b0;
	logic                       arst_n       = 1'b0;
	logic                       cfg_write    = 1'b0;
	logic                       cfg_index    = CFG_THRESH_4;
	logic [THRESH_W-1:0]        cfg_wdata    = '0;
	logic                       in_valid     = 1'b0;
	logic                       in_stall;
	logic                       kind         = KIND_UPDATE;
	logic [SITE_W-1:0]          site_index   = '0;
	logic [RAND_W-1:0]          random_value = '0;
	logic                       spin_value   = SPIN_UP;
	logic                       out_valid;
	logic                       out_stall    = 1'b0;
	logic                       accepted;
	logic signed [ENERGY_W-1:0] energy;
	logic [MAG_W-1:0]           magnetisation_abs;

	// Lattice predictor state
	bit                         lattice_up [VOL];
	int                         energy_sum;
	int                         magnet_sum;
	logic [THRESH_W-1:0]        bound_4;
	logic [THRESH_W-1:0]        bound_8;

	site_result_t               due_results [$];
	int                         mismatches   = 0;
	int                         quiet_cycles = 0;
	int                         send_idle_pct = 0;
	int                         recv_idle_pct = 0;
	int                         holdoff_left  = 0;
	int                         last_site     = 0;

	ising_metropolis_site_update dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---- predictor -----------------------------------------------------------

	function automatic int spin_of(int r, int c);
		return lattice_up[(r % SIDE) * SIDE + (c % SIDE)] ? 1 : -1;
	endfunction

	// Applies one transaction to the lattice copy and returns its result.
	function automatic site_result_t metropolis_step(logic k, logic [SITE_W-1:0] site,
			logic [RAND_W-1:0] rnd, logic spin);
		int row, col, h, s, de, m;
		bit flip;
		site_result_t r;
		flip = 1'b0;
		if (int'(site) < VOL) begin
			row = int'(site) / SIDE;
			col = int'(site) % SIDE;
			h = spin_of(row + 1, col) + spin_of(row + SIDE - 1, col)
			  + spin_of(row, col + 1) + spin_of(row, col + SIDE - 1);
			s = lattice_up[site] ? 1 : -1;
			de = 2 * s * h;
			if (k == KIND_UPDATE)
				flip = (de <= 0) || (de == 4 ? rnd < bound_4 : rnd < bound_8);
			else
				flip = (lattice_up[site] != (spin == SPIN_UP));
			if (flip) begin
				lattice_up[site] = !lattice_up[site];
				energy_sum += de;
				magnet_sum -= 2 * s;
			end
		end
		m = magnet_sum < 0 ? -magnet_sum : magnet_sum;
		r.accepted          = flip && (k == KIND_UPDATE);
		r.energy            = ENERGY_W'(energy_sum);
		r.magnetisation_abs = MAG_W'(m);
		return r;
	endfunction

	// ---- stimulus helpers ----------------------------------------------------

	// Offers one transaction, with random idle cycles ahead of it, and
	// records its prediction once the block takes it. Valid stays high on
	// return so back-to-back transactions need no gap.
	task automatic send_item(logic k, int site, logic [RAND_W-1:0] rnd, logic spin);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid     <= 1'b1;
		kind         <= k;
		site_index   <= SITE_W'(site);
		random_value <= rnd;
		spin_value   <= spin;
		do
			@(posedge clk);
		while (in_stall);
		due_results.insert(due_results.size(), metropolis_step(k, SITE_W'(site), rnd, spin));
		last_site = site;
	endtask

	// Sender pauses until every result is back, then lets the pipe settle.
	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		wait (due_results.size() == 0);
		repeat (DRAIN_GAP) @(posedge clk);
	endtask

	// Called with no transaction in flight; the first call falls in the clearing pass.
	task automatic write_thresholds(logic [THRESH_W-1:0] t4, logic [THRESH_W-1:0] t8);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= CFG_THRESH_4;
		cfg_wdata <= t4;
		@(negedge clk);
		cfg_index <= CFG_THRESH_8;
		cfg_wdata <= t8;
		@(negedge clk);
		cfg_write <= 1'b0;
		bound_4 = t4;
		bound_8 = t8;
	endtask

	// Mostly the same site or a torus neighbour of the last one (forwarding
	// hazards), some in a patch straddling the corner wrap, the rest anywhere.
	function automatic int pick_site();
		int sel, r, c;
		sel = $urandom_range(0, 99);
		r = last_site / SIDE;
		c = last_site % SIDE;
		if (sel < 15)
			return last_site;
		if (sel < 55) begin
			case ($urandom_range(0, 3))
				0:       r = (r + 1) % SIDE;
				1:       r = (r + SIDE - 1) % SIDE;
				2:       c = (c + 1) % SIDE;
				default: c = (c + SIDE - 1) % SIDE;
			endcase
			return r * SIDE + c;
		end
		if (sel < 80)
			return ((SIDE - 2 + $urandom_range(0, 3)) % SIDE) * SIDE
			     + ((SIDE - 2 + $urandom_range(0, 3)) % SIDE);
		return $urandom_range(0, VOL - 1);
	endfunction

	// ---- tests ---------------------------------------------------------------

	// Thresholds at zero: an update flips only for dE <= 0. Sets, wrap and dE cases.
	task automatic test_directed_cases();
		write_thresholds('0, '0);
		send_item(KIND_UPDATE, 0, '0, SPIN_UP);            // dE 8, zero bound
		send_item(KIND_UPDATE, 0, '1, ~SPIN_UP);           // dE 8, top random
		send_item(KIND_SET, 0, '0, SPIN_UP);               // set to same spin
		send_item(KIND_SET, 0, '0, ~SPIN_UP);              // set flips
		send_item(KIND_UPDATE, 1, '0, SPIN_UP);            // dE 4, rejected
		send_item(KIND_UPDATE, 0, '0, SPIN_UP);            // dE -8 flips back
		send_item(KIND_SET, VOL - 1, '0, ~SPIN_UP);        // far corner down
		send_item(KIND_SET, SIDE - 1, '0, ~SPIN_UP);       // its wrapped neighbour
		send_item(KIND_UPDATE, VOL - SIDE, '0, SPIN_UP);   // wrap left, dE 4
		send_item(KIND_UPDATE, VOL - 1, '0, SPIN_UP);      // dE -4 flips
		send_item(KIND_UPDATE, SIDE - 1, '0, SPIN_UP);     // dE -8 flips
		send_item(KIND_SET, 1, '0, ~SPIN_UP);
		send_item(KIND_SET, SIDE, '0, ~SPIN_UP);
		send_item(KIND_UPDATE, 0, 32'h8000_0000, SPIN_UP); // dE 0 flips
		send_item(KIND_UPDATE, 0, '1, SPIN_UP);            // dE 0 flips back
		drain_results();
	endtask

	// Strict-less-than comparison at both ends of the threshold range.
	task automatic test_threshold_edges();
		write_thresholds(32'd1, 32'd1);
		send_item(KIND_UPDATE, 2048, 32'd1, SPIN_UP);       // dE 8, equal: reject
		send_item(KIND_UPDATE, 2048, 32'd0, SPIN_UP);       // dE 8, below: accept
		send_item(KIND_UPDATE, 2049, 32'd1, SPIN_UP);       // dE 4, reject
		send_item(KIND_UPDATE, 2049, 32'd0, SPIN_UP);       // dE 4, accept
		drain_results();
		write_thresholds('1, '1);
		send_item(KIND_UPDATE, 1000, '1, SPIN_UP);          // never accepted
		send_item(KIND_UPDATE, 1000, 32'hFFFF_FFFE, SPIN_UP);
		send_item(KIND_UPDATE, 1001, '1, SPIN_UP);
		send_item(KIND_UPDATE, 1001, 32'h8000_0000, SPIN_UP);
		drain_results();
	endtask

	task automatic test_random_traffic(int items, logic [THRESH_W-1:0] t4,
			logic [THRESH_W-1:0] t8, int send_pct, int recv_pct);
		int site, sel;
		logic [RAND_W-1:0] rnd;
		write_thresholds(t4, t8);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		repeat (items) begin
			site = pick_site();
			sel = $urandom_range(0, 19);
			case (sel)
				0:       rnd = t4;
				1:       rnd = t4 - 1;
				2:       rnd = t8;
				3:       rnd = t8 - 1;
				default: rnd = $urandom();
			endcase
			send_item($urandom_range(0, 3) == 0 ? KIND_SET : KIND_UPDATE, site, rnd,
				logic'($urandom_range(0, 1)));
		end
		drain_results();
	endtask

	// Receiver holds off long enough for the block to back up onto its input.
	task automatic test_output_holdoff();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		@(posedge clk);
		holdoff_left = HOLDOFF_LEN;
		repeat (16)
			send_item($urandom_range(0, 1) ? KIND_SET : KIND_UPDATE, pick_site(),
				$urandom(), logic'($urandom_range(0, 1)));
		drain_results();
	endtask

	// ---- receiver and checker ------------------------------------------------

	always @(negedge clk) begin
		if (holdoff_left > 0) begin
			holdoff_left = holdoff_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		site_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (due_results.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("unexpected result transaction: acc %0b E %0d |M| %0d",
						accepted, energy, magnetisation_abs);
			end else begin
				want = due_results.pop_front();
				if (accepted !== want.accepted || energy !== want.energy
						|| magnetisation_abs !== want.magnetisation_abs) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("result mismatch: acc %0b/%0b E %0d/%0d |M| %0d/%0d (exp/got)",
							want.accepted, accepted, want.energy, energy,
							want.magnetisation_abs, magnetisation_abs);
				end
			end
		end
	end

	// Hang detector: any transaction on either channel restarts the count.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
			$display("tb_ising_metropolis_site_update: errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ---- sequence ------------------------------------------------------------

	initial begin
		foreach (lattice_up[i])
			lattice_up[i] = 1'b1;
		energy_sum = -2 * VOL;
		magnet_sum = VOL;
		bound_4    = '0;
		bound_8    = '0;

		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		test_directed_cases();
		test_threshold_edges();
		// near the critical point, then arbitrary bounds, then hot
		test_random_traffic(600, 32'h2C11_0000, 32'h07A0_0000, 21, 61);
		test_random_traffic(600, $urandom(), $urandom(), 61, 21);
		test_random_traffic(600, 32'hC000_0000, 32'h9000_0000, 0, 0);
		test_output_holdoff();

		if (mismatches == 0 && due_results.size() == 0) begin
			$display("tb_ising_metropolis_site_update: clean");
		end else begin
			$display("tb_ising_metropolis_site_update: errors");
		end
		$finish;
	end

endmodule
